FILE: sv/peripheral_dma_register_block_assert.svh
// Assertion macros shared by the peripheral DMA register block RTL.
// Depends on nothing; included by the files that carry concurrent assertions.
`ifndef PERIPHERAL_DMA_REGISTER_BLOCK_ASSERT_SVH
`define PERIPHERAL_DMA_REGISTER_BLOCK_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PDMA_ASSERT_IMPL(LBL, CLK, RSTN, ANT, CON, MSG) \
    LBL: assert property (@(posedge CLK) disable iff (!RSTN) (ANT) |-> (CON)) \
        else $error(MSG);

// Next-cycle implication, disabled while reset is asserted.
`define PDMA_ASSERT_NEXT(LBL, CLK, RSTN, ANT, CON, MSG) \
    LBL: assert property (@(posedge CLK) disable iff (!RSTN) (ANT) |=> (CON)) \
        else $error(MSG);

`endif

FILE: sv/pdma_pkg.sv
// Types and constants of the peripheral DMA register block.
// Depends on nothing; used by every module of the block.
`default_nettype none

package pdma_pkg;

    localparam logic CMD_READ  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    localparam logic [3:0] REG_DRAM_ADDR  = 4'd0;
    localparam logic [3:0] REG_CART_ADDR  = 4'd1;
    localparam logic [3:0] REG_RD_LEN     = 4'd2;
    localparam logic [3:0] REG_WR_LEN     = 4'd3;
    localparam logic [3:0] REG_STATUS     = 4'd4;
    localparam logic [3:0] REG_STUB_FIRST = 4'd5;
    localparam logic [3:0] REG_STUB_LAST  = 4'd12;

    localparam int unsigned STATUS_CLR_IRQ_BIT = 1;
    localparam int unsigned STATUS_IRQ_BIT     = 3;

    localparam int unsigned LEN_W     = 25;
    localparam int unsigned DRAM_AW   = 23;
    localparam int unsigned STUB_CNT  = 8;

    localparam logic [31:0] CART_ALIGN_MASK = 32'hFFFF_FFFE;
    localparam logic [31:0] DRAM_ALIGN_MASK = 32'h007F_FFFE;
    localparam logic [31:0] CART_MASK_RESET = 32'hFFFF_FFFF;

    typedef struct packed {
        logic        command;
        logic [3:0]  register_index;
        logic [31:0] write_data;
    } t_req;

    typedef struct packed {
        logic [31:0]        read_data;
        logic               access_error;
        logic               dma_start;
        logic               dma_to_cart;
        logic [DRAM_AW-1:0] dma_dram_address;
        logic [31:0]        dma_cart_address;
        logic [LEN_W-1:0]   dma_length;
        logic               interrupt_level;
    } t_rsp;

endpackage

`default_nettype wire

FILE: sv/pdma_req_if.sv
// Request channel of the peripheral DMA register block: one bus access.
// Depends on nothing.
`default_nettype none

interface pdma_req_if;
    logic        valid;
    logic        ready;
    logic        command;
    logic [3:0]  register_index;
    logic [31:0] write_data;

    modport source (output valid, output command, output register_index,
                    output write_data, input ready);
    modport sink   (input valid, input command, input register_index,
                    input write_data, output ready);
endinterface

`default_nettype wire

FILE: sv/pdma_rsp_if.sv
// Result channel of the peripheral DMA register block: read data and DMA launch.
// Depends on nothing.
`default_nettype none

interface pdma_rsp_if;
    logic        valid;
    logic        ready;
    logic [31:0] read_data;
    logic        access_error;
    logic        dma_start;
    logic        dma_to_cart;
    logic [22:0] dma_dram_address;
    logic [31:0] dma_cart_address;
    logic [24:0] dma_length;
    logic        interrupt_level;

    modport source (output valid, output read_data, output access_error,
                    output dma_start, output dma_to_cart, output dma_dram_address,
                    output dma_cart_address, output dma_length,
                    output interrupt_level, input ready);
    modport sink   (input valid, input read_data, input access_error,
                    input dma_start, input dma_to_cart, input dma_dram_address,
                    input dma_cart_address, input dma_length,
                    input interrupt_level, output ready);
endinterface

`default_nettype wire

FILE: sv/peripheral_dma_register_block.sv
// Top level of the peripheral DMA register block: request register, register
// file and result register. Depends on pdma_pkg, the two channel interfaces,
// pdma_in_stage, pdma_regs and the assertion macro header.
`default_nettype none
`include "peripheral_dma_register_block_assert.svh"

// This block serves one bus request per clock cycle while the result side does
// not stall: a read or write of one word register of the cartridge peripheral
// interface. Each request passes through the input register and then the
// result register, and a new request can be accepted before the last one has
// left; each request reads and writes the pointer and length registers in the
// same cycle, as it leaves the input register. Writing register 2 (DRAM to
// cartridge) or register 3 (cartridge to DRAM) launches a transfer: the result
// carries dma_start with the aligned DRAM address, the cartridge address masked
// by the configured ROM mask, and the byte count, and the interrupt flag is
// raised. The DRAM address on the result is limited to DRAM_ADDRESS_BITS bits.
// Writing the status register with bit 1 set clears the interrupt; reading it
// shows the flag at bit 3. Indices 5 to 12 are byte-wide stub registers and
// indices 13 to 15 report an access error. When the result side stalls, the
// result register holds and the input register can still take one more
// request. The cartridge mask is written through its own write channel, which
// is always ready, and should be changed only while no request is in flight.
module peripheral_dma_register_block #(
    parameter int unsigned DRAM_ADDRESS_BITS = 23
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    pdma_req_if.sink         i_req,
    pdma_rsp_if.source       o_rsp,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [31:0] i_cfg_wdata
);

    // Bits of the emitted DRAM address that survive the address space limit.
    localparam int unsigned DramKeep = (DRAM_ADDRESS_BITS < pdma_pkg::DRAM_AW)
                                     ? DRAM_ADDRESS_BITS : pdma_pkg::DRAM_AW;
    localparam logic [pdma_pkg::DRAM_AW-1:0] DramOutMask =
        pdma_pkg::DRAM_AW'((64'd1 << DramKeep) - 64'd1);

    logic           cfg_we;
    logic [31:0]    r_cart_mask;
    pdma_pkg::t_req s1_item;
    logic           s1_valid;
    logic           s1_advance;
    logic           s1_fire;
    pdma_pkg::t_rsp s1_rsp;
    logic           r_out_valid;
    pdma_pkg::t_rsp r_out, n_out;

    // The mask register accepts a write in any cycle.
    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cart_mask <= pdma_pkg::CART_MASK_RESET;
        end else if (cfg_we) begin
            r_cart_mask <= i_cfg_wdata;
        end
    end

    // The request in the input register moves on when the result register is
    // empty or is being emptied by the consumer in this cycle.
    assign s1_advance = !r_out_valid || o_rsp.ready;
    assign s1_fire    = s1_valid && s1_advance;

    pdma_in_stage u_in_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (i_req),
        .i_advance (s1_advance),
        .o_item    (s1_item),
        .o_valid   (s1_valid)
    );

    pdma_regs u_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (s1_fire),
        .i_item      (s1_item),
        .i_cart_mask (r_cart_mask),
        .o_rsp       (s1_rsp)
    );

    always_comb begin
        n_out                  = s1_rsp;
        n_out.dma_dram_address = s1_rsp.dma_dram_address & DramOutMask;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_advance) begin
            r_out_valid <= s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire) begin
            r_out <= n_out;
        end
    end

    assign o_rsp.valid            = r_out_valid;
    assign o_rsp.read_data        = r_out.read_data;
    assign o_rsp.access_error     = r_out.access_error;
    assign o_rsp.dma_start        = r_out.dma_start;
    assign o_rsp.dma_to_cart      = r_out.dma_to_cart;
    assign o_rsp.dma_dram_address = r_out.dma_dram_address;
    assign o_rsp.dma_cart_address = r_out.dma_cart_address;
    assign o_rsp.dma_length       = r_out.dma_length;
    assign o_rsp.interrupt_level  = r_out.interrupt_level;

    // A launched transfer always leaves the interrupt raised.
    `PDMA_ASSERT_IMPL(a_dma_raises_irq, i_clk, i_rst_n,
        o_rsp.valid && o_rsp.dma_start, o_rsp.interrupt_level,
        "transfer result without interrupt")
    // An accepted request must occupy the input register in the next cycle.
    `PDMA_ASSERT_NEXT(a_req_captured, i_clk, i_rst_n,
        i_rst_n && i_req.valid && i_req.ready, s1_valid,
        "accepted request was lost")
    // A request leaving the input register must land in the result register.
    `PDMA_ASSERT_NEXT(a_rsp_captured, i_clk, i_rst_n,
        i_rst_n && s1_fire, r_out_valid,
        "processed request produced no result")
    // A transfer has an even DRAM address and at most 16 MiB of length.
    `PDMA_ASSERT_IMPL(a_dma_shape, i_clk, i_rst_n,
        o_rsp.valid && o_rsp.dma_start,
        !o_rsp.dma_dram_address[0] && (o_rsp.dma_length <= 25'h100_0000),
        "malformed transfer")
    // An access error never launches a transfer nor returns data.
    `PDMA_ASSERT_IMPL(a_error_quiet, i_clk, i_rst_n,
        o_rsp.valid && o_rsp.access_error,
        !o_rsp.dma_start && (o_rsp.read_data == 32'd0),
        "access error with side effects")

endmodule

`default_nettype wire

FILE: sv/pdma_in_stage.sv
// Input register of the peripheral DMA register block.
// Depends on pdma_pkg and pdma_req_if.
`default_nettype none

module pdma_in_stage (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    pdma_req_if.sink           i_req,
    input  wire logic          i_advance,
    output pdma_pkg::t_req     o_item,
    output logic               o_valid
);

    logic           r_valid;
    pdma_pkg::t_req r_item;
    logic           in_ready;

    // The stage takes a new request whenever it is empty or drains this cycle.
    assign in_ready    = !r_valid || i_advance;
    assign i_req.ready = in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (in_ready) begin
            r_valid <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_ready && i_req.valid) begin
            r_item.command        <= i_req.command;
            r_item.register_index <= i_req.register_index;
            r_item.write_data     <= i_req.write_data;
        end
    end

    assign o_item  = r_item;
    assign o_valid = r_valid;

endmodule

`default_nettype wire

FILE: sv/pdma_regs.sv
// Register file and access decode of the peripheral DMA register block.
// Depends on pdma_pkg.
`default_nettype none

module pdma_regs (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_fire,
    input  wire pdma_pkg::t_req i_item,
    input  wire logic [31:0]    i_cart_mask,
    output pdma_pkg::t_rsp      o_rsp
);

    logic [31:0]                r_dram_ptr, n_dram_ptr;
    logic [31:0]                r_cart_ptr, n_cart_ptr;
    logic [pdma_pkg::LEN_W-1:0] r_rd_len, n_rd_len;
    logic [pdma_pkg::LEN_W-1:0] r_wr_len, n_wr_len;
    logic                       r_irq, n_irq;
    logic [7:0]                 r_stub [pdma_pkg::STUB_CNT];
    logic                       stub_we;

    logic [2:0]                 stub_sel;
    logic [31:0]                cart_al;
    logic [31:0]                dram_al;
    logic [pdma_pkg::LEN_W-1:0] len_raw;
    logic [pdma_pkg::LEN_W-1:0] mis;
    logic [pdma_pkg::LEN_W-1:0] len;
    logic                       is_write;

    assign is_write = (i_item.command == pdma_pkg::CMD_WRITE);
    assign stub_sel = 3'(i_item.register_index - pdma_pkg::REG_STUB_FIRST);

    // Transfer setup: align both addresses, then trim the length by the
    // DRAM misalignment, clamping at zero.
    assign cart_al = r_cart_ptr & pdma_pkg::CART_ALIGN_MASK;
    assign dram_al = r_dram_ptr & pdma_pkg::DRAM_ALIGN_MASK;
    assign len_raw = {1'b0, i_item.write_data[23:0]} + 25'd1;
    assign mis     = {22'd0, dram_al[2:0]};
    assign len     = (len_raw > mis) ? (len_raw - mis) : '0;

    always_comb begin
        n_dram_ptr = r_dram_ptr;
        n_cart_ptr = r_cart_ptr;
        n_rd_len   = r_rd_len;
        n_wr_len   = r_wr_len;
        n_irq      = r_irq;
        stub_we    = 1'b0;
        o_rsp      = '0;

        if (is_write) begin
            unique case (i_item.register_index) inside
                pdma_pkg::REG_DRAM_ADDR: n_dram_ptr = i_item.write_data;
                pdma_pkg::REG_CART_ADDR: n_cart_ptr = i_item.write_data;
                pdma_pkg::REG_RD_LEN, pdma_pkg::REG_WR_LEN: begin
                    if (i_item.register_index == pdma_pkg::REG_RD_LEN) begin
                        n_rd_len = len;
                    end else begin
                        n_wr_len = len;
                    end
                    o_rsp.dma_start        = 1'b1;
                    o_rsp.dma_to_cart      = (i_item.register_index == pdma_pkg::REG_RD_LEN);
                    o_rsp.dma_dram_address = dram_al[pdma_pkg::DRAM_AW-1:0];
                    o_rsp.dma_cart_address = cart_al & i_cart_mask;
                    o_rsp.dma_length       = len;
                    n_dram_ptr             = dram_al + {7'd0, len};
                    n_cart_ptr             = cart_al + {7'd0, len};
                    n_irq                  = 1'b1;
                end
                pdma_pkg::REG_STATUS: begin
                    if (i_item.write_data[pdma_pkg::STATUS_CLR_IRQ_BIT]) begin
                        n_irq = 1'b0;
                    end
                end
                [pdma_pkg::REG_STUB_FIRST:pdma_pkg::REG_STUB_LAST]: stub_we = 1'b1;
                default: o_rsp.access_error = 1'b1;
            endcase
        end else begin
            unique case (i_item.register_index) inside
                pdma_pkg::REG_DRAM_ADDR: o_rsp.read_data = r_dram_ptr;
                pdma_pkg::REG_CART_ADDR: o_rsp.read_data = r_cart_ptr;
                pdma_pkg::REG_RD_LEN:    o_rsp.read_data = {7'd0, r_rd_len};
                pdma_pkg::REG_WR_LEN:    o_rsp.read_data = {7'd0, r_wr_len};
                pdma_pkg::REG_STATUS:    o_rsp.read_data[pdma_pkg::STATUS_IRQ_BIT] = r_irq;
                [pdma_pkg::REG_STUB_FIRST:pdma_pkg::REG_STUB_LAST]:
                    o_rsp.read_data = {24'd0, r_stub[stub_sel]};
                default: o_rsp.access_error = 1'b1;
            endcase
        end

        o_rsp.interrupt_level = n_irq;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dram_ptr <= '0;
            r_cart_ptr <= '0;
            r_rd_len   <= '0;
            r_wr_len   <= '0;
            r_irq      <= 1'b0;
            for (int k = 0; k < pdma_pkg::STUB_CNT; k++) begin
                r_stub[k] <= '0;
            end
        end else if (i_fire) begin
            r_dram_ptr <= n_dram_ptr;
            r_cart_ptr <= n_cart_ptr;
            r_rd_len   <= n_rd_len;
            r_wr_len   <= n_wr_len;
            r_irq      <= n_irq;
            if (stub_we) begin
                r_stub[stub_sel] <= i_item.write_data[7:0];
            end
        end
    end

endmodule

`default_nettype wire

FILE: bench/peripheral_dma_register_block_tb.sv
// Self-checking bench for the peripheral DMA register block: directed and random bus requests,
// with every response predicted in-bench. Depends on pdma_pkg, pdma_req_if, pdma_rsp_if
// and the block itself.

module peripheral_dma_register_block_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned DRAM_BITS       = 23;
    localparam int unsigned HALF_PERIOD     = 4;
    localparam int unsigned CYCLE_LIMIT     = 100000;
    localparam int unsigned ITEMS_PER_PHASE = 108;
    localparam int unsigned PRESSURE_CYCLES = 300;
    // Wait after the last response so that both registers of the block empty.
    localparam int unsigned DRAIN_CYCLES    = 6;

    // Shadow copy of the register file. Each accepted request updates the shadow
    // and queues the response the block must return for it; each observed response
    // is checked against the oldest queued one.
    class dma_register_shadow;
        logic [31:0]                cart_mask;
        logic [31:0]                dram_ptr;
        logic [31:0]                cart_ptr;
        logic [pdma_pkg::LEN_W-1:0] read_len;
        logic [pdma_pkg::LEN_W-1:0] write_len;
        logic                       irq;
        logic [7:0]                 stub [pdma_pkg::STUB_CNT];
        pdma_pkg::t_rsp             pending_responses [$];
        int unsigned                mismatches;

        function new();
            cart_mask  = pdma_pkg::CART_MASK_RESET;
            dram_ptr   = '0;
            cart_ptr   = '0;
            read_len   = '0;
            write_len  = '0;
            irq        = 1'b0;
            mismatches = 0;
            foreach (stub[k]) stub[k] = '0;
        endfunction

        function void set_cart_mask(logic [31:0] value);
            cart_mask = value;
        endfunction

        function void log_access(pdma_pkg::t_req acc);
            pdma_pkg::t_rsp             r;
            logic [31:0]                cart;
            logic [31:0]                dram;
            logic [31:0]                dram_out;
            logic [63:0]                dram_space;
            logic [pdma_pkg::LEN_W-1:0] len;
            logic [pdma_pkg::LEN_W-1:0] mis;
            logic [2:0]                 slot;

            r = '0;
            slot = 3'(acc.register_index - pdma_pkg::REG_STUB_FIRST);
            if (acc.register_index > pdma_pkg::REG_STUB_LAST) begin
                r.access_error = 1'b1;
            end else if (acc.command == pdma_pkg::CMD_WRITE) begin
                case (acc.register_index)
                    pdma_pkg::REG_DRAM_ADDR: dram_ptr = acc.write_data;
                    pdma_pkg::REG_CART_ADDR: cart_ptr = acc.write_data;
                    pdma_pkg::REG_RD_LEN, pdma_pkg::REG_WR_LEN: begin
                        cart = cart_ptr & pdma_pkg::CART_ALIGN_MASK;
                        dram = dram_ptr & pdma_pkg::DRAM_ALIGN_MASK;
                        len  = {1'b0, acc.write_data[23:0]} + 1'b1;
                        mis  = pdma_pkg::LEN_W'(dram[2:0]);
                        // Misalignment at least as large as the count leaves nothing to copy.
                        len  = (len > mis) ? len - mis : '0;
                        if (acc.register_index == pdma_pkg::REG_RD_LEN) read_len = len;
                        else write_len = len;
                        dram_space = (64'd1 << DRAM_BITS) - 64'd1;
                        dram_out   = dram & dram_space[31:0];
                        r.dma_start        = 1'b1;
                        r.dma_to_cart      = (acc.register_index == pdma_pkg::REG_RD_LEN);
                        r.dma_dram_address = dram_out[pdma_pkg::DRAM_AW-1:0];
                        r.dma_cart_address = cart & cart_mask;
                        r.dma_length       = len;
                        dram_ptr = dram + 32'(len);
                        cart_ptr = cart + 32'(len);
                        irq = 1'b1;
                    end
                    pdma_pkg::REG_STATUS: begin
                        if (acc.write_data[pdma_pkg::STATUS_CLR_IRQ_BIT]) irq = 1'b0;
                    end
                    default: stub[slot] = acc.write_data[7:0];
                endcase
            end else begin
                case (acc.register_index)
                    pdma_pkg::REG_DRAM_ADDR: r.read_data = dram_ptr;
                    pdma_pkg::REG_CART_ADDR: r.read_data = cart_ptr;
                    pdma_pkg::REG_RD_LEN:    r.read_data = 32'(read_len);
                    pdma_pkg::REG_WR_LEN:    r.read_data = 32'(write_len);
                    pdma_pkg::REG_STATUS:    r.read_data[pdma_pkg::STATUS_IRQ_BIT] = irq;
                    default:                 r.read_data = 32'(stub[slot]);
                endcase
            end
            r.interrupt_level = irq;
            pending_responses.push_back(r);
        endfunction

        function void compare_field(string field, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                $display("%0t: %s expected %h, got %h", $time, field, want, got);
                mismatches++;
            end
        endfunction

        function void check_response(pdma_pkg::t_rsp got);
            pdma_pkg::t_rsp want;
            if (pending_responses.size() == 0) begin
                $display("%0t: response expected none, got read_data %h dma_start %b",
                         $time, got.read_data, got.dma_start);
                mismatches++;
                return;
            end
            want = pending_responses.pop_front();
            compare_field("read_data", want.read_data, got.read_data);
            compare_field("access_error", 32'(want.access_error), 32'(got.access_error));
            compare_field("dma_start", 32'(want.dma_start), 32'(got.dma_start));
            compare_field("dma_to_cart", 32'(want.dma_to_cart), 32'(got.dma_to_cart));
            compare_field("dma_dram_address", 32'(want.dma_dram_address),
                          32'(got.dma_dram_address));
            compare_field("dma_cart_address", want.dma_cart_address, got.dma_cart_address);
            compare_field("dma_length", 32'(want.dma_length), 32'(got.dma_length));
            compare_field("interrupt_level", 32'(want.interrupt_level),
                          32'(got.interrupt_level));
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [31:0] i_cfg_wdata;

    pdma_req_if req_ch ();
    pdma_rsp_if rsp_ch ();

    dma_register_shadow shadow = new();

    // Set by the stimulus, read by the response sink.
    bit          idle_on = 1'b1;
    int unsigned pressure_left = 0;
    int unsigned requests_sent = 0;
    int unsigned cycle_count = 0;

    peripheral_dma_register_block #(
        .DRAM_ADDRESS_BITS(DRAM_BITS)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (req_ch),
        .o_rsp      (rsp_ch),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_wdata(i_cfg_wdata)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    // Run watchdog: a hung handshake or a lost response ends the run here.
    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    // Response sink. Every response taken at a clock edge is checked against the
    // shadow. Ready is then chosen for the next edge: held low for the whole of a
    // pressure window, otherwise dropped in bursts of random length while idling
    // is enabled, and held high once idling is switched off.
    initial begin : response_sink
        pdma_pkg::t_rsp got;
        int unsigned    stall_left;

        stall_left = 0;
        rsp_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
                got.read_data        = rsp_ch.read_data;
                got.access_error     = rsp_ch.access_error;
                got.dma_start        = rsp_ch.dma_start;
                got.dma_to_cart      = rsp_ch.dma_to_cart;
                got.dma_dram_address = rsp_ch.dma_dram_address;
                got.dma_cart_address = rsp_ch.dma_cart_address;
                got.dma_length       = rsp_ch.dma_length;
                got.interrupt_level  = rsp_ch.interrupt_level;
                shadow.check_response(got);
            end
            if (pressure_left > 0) begin
                pressure_left--;
                rsp_ch.ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                rsp_ch.ready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 9) == 0) begin
                stall_left = $urandom_range(0, 15);
                rsp_ch.ready <= 1'b0;
            end else begin
                rsp_ch.ready <= 1'b1;
            end
        end
    end

    // Offers one request and holds it until the block takes it. Valid stays high
    // into the next request unless a random gap is inserted; no gaps are inserted
    // during a pressure window so that the block fills up behind the stalled sink.
    task automatic access(input logic cmd, input logic [3:0] index, input logic [31:0] data);
        pdma_pkg::t_req acc;
        acc.command        = cmd;
        acc.register_index = index;
        acc.write_data     = data;
        req_ch.valid          <= 1'b1;
        req_ch.command        <= cmd;
        req_ch.register_index <= index;
        req_ch.write_data     <= data;
        do @(posedge i_clk); while (!req_ch.ready);
        shadow.log_access(acc);
        requests_sent++;
        if (idle_on && pressure_left == 0 && $urandom_range(0, 5) == 0) begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
    endtask

    // Waits until every response has come back, then lets the pipeline empty.
    task automatic settle();
        req_ch.valid <= 1'b0;
        while (shadow.pending_responses.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // The mask is only changed with no request in flight.
    task automatic write_cart_mask(input logic [31:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_wdata <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        shadow.set_cart_mask(value);
        i_cfg_valid <= 1'b0;
    endtask

    // Pointer values near the ends of the address space and the DRAM window,
    // small values, and anything else.
    function automatic logic [31:0] pick_address();
        case ($urandom_range(0, 5))
            0:       return 32'hFFFF_FFFF - $urandom_range(0, 63);
            1:       return 32'($urandom_range(0, 63));
            2:       return 32'h007F_FFF0 + $urandom_range(0, 15);
            default: return $urandom();
        endcase
    endfunction

    // Very short counts hit the saturation against the DRAM misalignment; the
    // upper byte of the written value is always random since the block drops it.
    function automatic logic [31:0] pick_length();
        case ($urandom_range(0, 4))
            0:       return ($urandom() & 32'hFF00_0000) | $urandom_range(0, 7);
            1:       return ($urandom() & 32'hFF00_0000) | 32'h00FF_FFFF;
            2:       return $urandom();
            default: return ($urandom() & 32'hFF00_0000) | $urandom_range(0, 4095);
        endcase
    endfunction

    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 7))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'($urandom_range(0, 15));
            default: return $urandom();
        endcase
    endfunction

    // Hand-picked requests: pointer, length and status registers and two stubs read and
    // written, the unmapped indices, the status clear with and without its bit, a count that
    // saturates to zero, the largest count, and a cartridge pointer that wraps past the top.
    task automatic run_directed();
        access(pdma_pkg::CMD_READ,  pdma_pkg::REG_DRAM_ADDR, 32'h0000_0000);
        access(pdma_pkg::CMD_READ,  pdma_pkg::REG_STATUS,    32'h0000_0000);
        access(pdma_pkg::CMD_READ,  4'd13,                   32'hFFFF_FFFF);
        access(pdma_pkg::CMD_WRITE, pdma_pkg::REG_DRAM_ADDR, 32'hFFFF_FFFF);
        access(pdma_pkg::CMD_WRITE, pdma_pkg::REG_CART_ADDR, 32'hFFFF_FFFF);
        // DRAM misalignment of six against a count of one.
        access(pdma_pkg::CMD_WRITE, pdma_pkg::REG_RD_LEN,    32'h0000_0000);
        access(pdma_pkg::CMD_READ,  pdma_pkg::REG_STATUS,    32'h0000_0000);
        access(pdma_pkg::CMD_READ,  pdma_pkg::REG_RD_LEN,    32'h0000_0000);
        access(pdma_pkg::CMD_WRITE, pdma_pkg::REG_STATUS,    32'hFFFF_FFFD);
        access(pdma_pkg::CMD_WRITE, pdma_pkg::REG_STATUS,    32'h0000_0002);
        access(pdma_pkg::CMD_READ,  pdma_pkg::REG_STATUS,    32'hFFFF_FFFF);
        access(pdma_pkg::CMD_WRITE, pdma_pkg::REG_DRAM_ADDR, 32'h0001_2345);
        access(pdma_pkg::CMD_WRITE, pdma_pkg::REG_CART_ADDR, 32'hFFFF_FFF1);
        // Near-maximum count; the cartridge pointer wraps through zero.
        access(pdma_pkg::CMD_WRITE, pdma_pkg::REG_WR_LEN,    32'hFFFF_FFFF);
        access(pdma_pkg::CMD_READ,  pdma_pkg::REG_DRAM_ADDR, 32'h0000_0000);
        access(pdma_pkg::CMD_READ,  pdma_pkg::REG_CART_ADDR, 32'h0000_0000);
        access(pdma_pkg::CMD_READ,  pdma_pkg::REG_WR_LEN,    32'h0000_0000);
        // DRAM address is now aligned to eight, so the full count survives.
        access(pdma_pkg::CMD_WRITE, pdma_pkg::REG_RD_LEN,     32'h00FF_FFFF);
        access(pdma_pkg::CMD_READ,  pdma_pkg::REG_RD_LEN,     32'h0000_0000);
        access(pdma_pkg::CMD_WRITE, pdma_pkg::REG_STUB_FIRST, 32'hFFFF_FFAB);
        access(pdma_pkg::CMD_WRITE, pdma_pkg::REG_STUB_LAST,  32'hFFFF_FFFF);
        access(pdma_pkg::CMD_READ,  pdma_pkg::REG_STUB_FIRST, 32'h0000_0000);
        access(pdma_pkg::CMD_READ,  pdma_pkg::REG_STUB_LAST,  32'h0000_0000);
        access(pdma_pkg::CMD_READ,  4'd8,                     32'h0000_0000);
        access(pdma_pkg::CMD_WRITE, 4'd14,                    32'hFFFF_FFFF);
        access(pdma_pkg::CMD_READ,  4'd15,                    32'h0000_0000);
    endtask

    // Mostly well-formed transfer setups (pointers, count, read-back, sometimes a
    // status clear) with random content and some steps left out; the rest are
    // single requests to any index, the unmapped ones included.
    task automatic run_random(input int unsigned count, input bit with_pressure);
        int unsigned target;

        target = requests_sent + count;
        if (with_pressure) pressure_left = PRESSURE_CYCLES;
        while (requests_sent < target) begin
            if ($urandom_range(0, 9) < 6) begin
                if ($urandom_range(0, 4) != 0) begin
                    access(pdma_pkg::CMD_WRITE, pdma_pkg::REG_DRAM_ADDR, pick_address());
                end
                if ($urandom_range(0, 4) != 0) begin
                    access(pdma_pkg::CMD_WRITE, pdma_pkg::REG_CART_ADDR, pick_address());
                end
                access(pdma_pkg::CMD_WRITE,
                       $urandom_range(0, 1) ? pdma_pkg::REG_RD_LEN : pdma_pkg::REG_WR_LEN,
                       pick_length());
                access(pdma_pkg::CMD_READ, 4'($urandom_range(0, 4)), $urandom());
                if ($urandom_range(0, 2) == 0) begin
                    access(pdma_pkg::CMD_WRITE, pdma_pkg::REG_STATUS, $urandom());
                end
            end else begin
                access(1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)), pick_word());
            end
        end
    endtask

    // Main sequence. Reset is held first, then the cartridge mask is walked through
    // all ones, zero, a 16 MB ROM mask, a random value and all ones again, with a
    // batch of requests under each. The pressure window sits in the third batch,
    // and the last batch runs with no idling on either side.
    initial begin : stimulus
        i_rst_n               <= 1'b0;
        i_cfg_valid           <= 1'b0;
        i_cfg_wdata           <= '0;
        req_ch.valid          <= 1'b0;
        req_ch.command        <= pdma_pkg::CMD_READ;
        req_ch.register_index <= pdma_pkg::REG_DRAM_ADDR;
        req_ch.write_data     <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        write_cart_mask(32'hFFFF_FFFF);
        run_directed();
        settle();

        write_cart_mask(32'h0000_0000);
        run_random(ITEMS_PER_PHASE, 1'b0);
        settle();

        write_cart_mask(32'h00FF_FFFF);
        run_random(ITEMS_PER_PHASE, 1'b1);
        settle();

        write_cart_mask($urandom());
        run_random(ITEMS_PER_PHASE, 1'b0);
        settle();

        write_cart_mask(32'hFFFF_FFFF);
        idle_on = 1'b0;
        run_random(ITEMS_PER_PHASE, 1'b0);
        settle();

        if (shadow.mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
